// ===== rtl/lj_pkg.sv =====
// shared types, constants and register codes for the lennard-jones pair force block
package lj_pkg;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF_SQ  = 3'd0,
        CFG_SIGMA_SQ   = 3'd1,
        CFG_WELL_DEPTH = 3'd2,
        CFG_BOX_LEN_X  = 3'd3,
        CFG_BOX_LEN_Y  = 3'd4,
        CFG_BOX_LEN_Z  = 3'd5,
        CFG_SPECIES_A  = 3'd6,
        CFG_SPECIES_B  = 3'd7
    } t_cfg_reg;

    // register reset values
    localparam logic [47:0] RST_CUTOFF_SQ  = 48'd0;
    localparam logic [47:0] RST_SIGMA_SQ   = 48'h0100_0000_0000;
    localparam logic [31:0] RST_WELL_DEPTH = 32'h0001_0000;
    localparam logic [30:0] RST_BOX_LEN    = 31'h0010_0000;
    localparam logic [7:0]  RST_SPECIES    = 8'd0;

    // datapath widths and clamp values
    localparam int unsigned MUL_W  = 64;
    localparam int unsigned REM_W  = 48;
    localparam int unsigned S2_QW  = 48;
    localparam int unsigned T_QW   = 62;
    localparam int unsigned MAG_W  = 24;
    localparam int unsigned WD48_W = 38;

    localparam logic [47:0] CAP48     = 48'hFFFF_FFFF_FFFF;
    localparam logic [61:0] CAP62     = 62'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [47:0] HALF      = 48'h0000_8000_0000;
    localparam logic [47:0] FORCE_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] FORCE_NEG = 48'h8000_0000_0000;

    // input beat
    typedef struct packed {
        logic signed [31:0] pos_i_x;
        logic signed [31:0] pos_i_y;
        logic signed [31:0] pos_i_z;
        logic signed [31:0] pos_j_x;
        logic signed [31:0] pos_j_y;
        logic signed [31:0] pos_j_z;
        logic [7:0]         kind_i;
        logic [7:0]         kind_j;
    } t_in;

    // output beat
    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic               interacts;
        logic               clipped;
    } t_out;

    // per-pair state carried down the pipeline
    typedef struct packed {
        logic                        live;
        logic                        inter;
        logic                        sat;
        logic                        gneg;
        logic [2:0]                  neg;
        logic [2:0][MAG_W-1:0]       mag;
        logic [47:0]                 r2;
        logic [47:0]                 s2;
        logic [47:0]                 s6;
        logic [61:0]                 acc;
    } t_item;

endpackage

// ===== rtl/lj_mul.sv =====
// two-stage 64x64 multiplier lanes built from 32x32 partial products
module lj_mul #(
    parameter int unsigned Lanes = 1,
    parameter int unsigned SideW = 1
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_en,
    input  logic                                     i_valid,
    input  logic [Lanes-1:0][lj_pkg::MUL_W-1:0]      i_a,
    input  logic [Lanes-1:0][lj_pkg::MUL_W-1:0]      i_b,
    input  logic [SideW-1:0]                         i_side,
    output logic                                     o_valid,
    output logic [Lanes-1:0][2*lj_pkg::MUL_W-1:0]    o_prod,
    output logic [SideW-1:0]                         o_side
);

    localparam int unsigned HW = lj_pkg::MUL_W / 2;
    localparam int unsigned PW = 2 * lj_pkg::MUL_W;

    logic                           r_v1;
    logic [Lanes-1:0][2*HW-1:0]     r_p00, r_p01, r_p10, r_p11;
    logic [SideW-1:0]               r_side1;
    logic                           r_v2;
    logic [Lanes-1:0][PW-1:0]       r_prod;
    logic [SideW-1:0]               r_side2;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < Lanes; k++) begin
                r_p00[k] <= (2*HW)'(i_a[k][HW-1:0])  * (2*HW)'(i_b[k][HW-1:0]);
                r_p01[k] <= (2*HW)'(i_a[k][HW-1:0])  * (2*HW)'(i_b[k][2*HW-1:HW]);
                r_p10[k] <= (2*HW)'(i_a[k][2*HW-1:HW]) * (2*HW)'(i_b[k][HW-1:0]);
                r_p11[k] <= (2*HW)'(i_a[k][2*HW-1:HW]) * (2*HW)'(i_b[k][2*HW-1:HW]);
            end
            r_side1 <= i_side;
        end
    end

    // partial product sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < Lanes; k++) begin
                r_prod[k] <= {{(2*HW){1'b0}}, r_p00[k]}
                           + {{HW{1'b0}}, r_p01[k], {HW{1'b0}}}
                           + {{HW{1'b0}}, r_p10[k], {HW{1'b0}}}
                           + {r_p11[k], {(2*HW){1'b0}}};
            end
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_v2;
    assign o_prod  = r_prod;
    assign o_side  = r_side2;

endmodule

// ===== rtl/lj_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with overflow clamp flag
module lj_div #(
    parameter int unsigned QW    = lj_pkg::S2_QW,
    parameter int unsigned SideW = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [lj_pkg::REM_W-1:0]  i_rem0,
    input  logic [QW-1:0]             i_low,
    input  logic [lj_pkg::REM_W-1:0]  i_den,
    input  logic [SideW-1:0]          i_side,
    output logic                      o_valid,
    output logic [QW-1:0]             o_quo,
    output logic                      o_sat,
    output logic [SideW-1:0]          o_side
);

    localparam int unsigned RW = lj_pkg::REM_W;

    logic              r_v    [0:QW];
    logic [QW-1:0]     r_quo  [0:QW];
    logic              r_sat  [0:QW];
    logic [SideW-1:0]  r_side [0:QW];
    logic [RW-1:0]     r_rem  [0:QW-1];
    logic [RW-1:0]     r_den  [0:QW-1];
    logic [QW-1:0]     r_low  [0:QW-1];

    // entry stage: top remainder at or above the divisor means the quotient overflows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_rem0;
            r_den[0]  <= i_den;
            r_low[0]  <= i_low;
            r_quo[0]  <= '0;
            r_sat[0]  <= (i_rem0 >= i_den);
            r_side[0] <= i_side;
        end
    end

    // one quotient bit per stage
    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [RW:0] w_trial;
        logic [RW:0] w_diff;
        logic        w_ge;

        assign w_trial = {r_rem[j], r_low[j][QW-1]};
        assign w_diff  = w_trial - {1'b0, r_den[j]};
        assign w_ge    = (w_trial >= {1'b0, r_den[j]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j+1]  <= {r_quo[j][QW-2:0], w_ge};
                r_sat[j+1]  <= r_sat[j];
                r_side[j+1] <= r_side[j];
            end
        end

        if (j < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j+1] <= w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
                    r_den[j+1] <= r_den[j];
                    r_low[j+1] <= {r_low[j][QW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_quo[QW];
    assign o_sat   = r_sat[QW];
    assign o_side  = r_side[QW];

endmodule

// ===== rtl/lj_front.sv =====
// pair front end: type match, periodic wrap, squared distance and cutoff test
module lj_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  lj_pkg::t_in           i_in,
    input  logic [2:0][30:0]      i_box,
    input  logic [7:0]            i_species_a,
    input  logic [7:0]            i_species_b,
    input  logic [47:0]           i_cutoff_sq,
    output logic                  o_valid,
    output lj_pkg::t_item         o_item
);

    localparam int unsigned MW = lj_pkg::MAG_W;

    logic [2:0][31:0]          w_pi, w_pj;

    logic                      r_a_v, r_b_v, r_c_v, r_d_v, r_e_v;
    logic signed [32:0]        r_a_d [3];
    logic                      r_a_match, r_b_match, r_c_match, r_d_match;

    logic signed [33:0]        w_dw  [3];
    logic [33:0]               w_mag [3];

    logic [2:0]                r_b_neg, r_c_neg, r_d_neg;
    logic [2:0][MW-1:0]        r_b_mag, r_c_mag, r_d_mag;
    logic [2:0]                r_b_big;
    logic [48:0]               r_c_sq [3];
    logic [49:0]               r_d_r2;
    lj_pkg::t_item             r_e_item;
    lj_pkg::t_item             n_e_item;

    assign w_pi = {i_in.pos_i_z, i_in.pos_i_y, i_in.pos_i_x};
    assign w_pj = {i_in.pos_j_z, i_in.pos_j_y, i_in.pos_j_x};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
        end
    end

    // stage a: coordinate differences and type match
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_a_d[k] <= $signed({w_pi[k][31], w_pi[k]}) - $signed({w_pj[k][31], w_pj[k]});
            end
            r_a_match <= (i_in.kind_i == i_species_a && i_in.kind_j == i_species_b)
                      || (i_in.kind_i == i_species_b && i_in.kind_j == i_species_a);
        end
    end

    // minimum image, single correction
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [33:0] d_ext, d_two, len_p, len_n;
            d_ext = {r_a_d[k][32], r_a_d[k]};
            d_two = {r_a_d[k], 1'b0};
            len_p = $signed({3'b000, i_box[k]});
            len_n = -len_p;
            if (d_two > len_p) begin
                w_dw[k] = d_ext - len_p;
            end else if (d_two < len_n) begin
                w_dw[k] = d_ext + len_p;
            end else begin
                w_dw[k] = d_ext;
            end
            w_mag[k] = w_dw[k][33] ? 34'(-w_dw[k]) : 34'(w_dw[k]);
        end
    end

    // stage b: sign and magnitude per axis
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_b_neg[k] <= w_dw[k][33];
                r_b_mag[k] <= w_mag[k][MW-1:0];
                r_b_big[k] <= |w_mag[k][33:MW];
            end
            r_b_match <= r_a_match;
        end
    end

    // stage c: squares, a far axis counts as 2^48
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_c_sq[k] <= r_b_big[k] ? {1'b1, 48'd0}
                           : {1'b0, 48'(r_b_mag[k]) * 48'(r_b_mag[k])};
            end
            r_c_neg   <= r_b_neg;
            r_c_mag   <= r_b_mag;
            r_c_match <= r_b_match;
        end
    end

    // stage d: squared distance
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_r2    <= 50'(r_c_sq[0]) + 50'(r_c_sq[1]) + 50'(r_c_sq[2]);
            r_d_neg   <= r_c_neg;
            r_d_mag   <= r_c_mag;
            r_d_match <= r_c_match;
        end
    end

    // stage e: cutoff test and coincident check
    always_comb begin
        n_e_item       = '0;
        n_e_item.inter = r_d_match && (r_d_r2 < {2'b00, i_cutoff_sq});
        n_e_item.live  = r_d_match && (r_d_r2 < {2'b00, i_cutoff_sq}) && (r_d_r2 != '0);
        n_e_item.neg   = r_d_neg;
        n_e_item.mag   = r_d_mag;
        n_e_item.r2    = r_d_r2[47:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_item <= n_e_item;
        end
    end

    assign o_valid = r_e_v;
    assign o_item  = r_e_item;

endmodule

// ===== rtl/lennard_jones_pair_force.sv =====
// top level: config registers, force pipeline and output skid stage
// depth: 133 register stages, counted from the input beat to the output register that offers the result beat
// throughput: one pair per cycle while the skid register is empty, every stage advances together on a shared enable
// depth is set by the two bit-serial-per-stage dividers (48 and 62 quotient bits)
// reset clears all valid bits, the skid stage and loads the default register values
// ready drops only while the skid register holds a second waiting result
module lennard_jones_pair_force (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  lj_pkg::t_in                    i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output lj_pkg::t_out                   o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lj_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lj_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int unsigned IW = $bits(lj_pkg::t_item);
    localparam int unsigned MW = lj_pkg::MUL_W;
    localparam int unsigned PW = 2 * lj_pkg::MUL_W;

    // config registers
    logic [47:0]                 r_cutoff_sq, r_sigma_sq;
    logic [31:0]                 r_well_depth;
    logic [2:0][30:0]            r_box;
    logic [7:0]                  r_species_a, r_species_b;
    logic [lj_pkg::WD48_W-1:0]   r_wd48;

    logic                        w_en;

    logic                        w_fe_v;
    lj_pkg::t_item               w_fe_item;

    logic                        w_d1_v, w_d1_sat;
    logic [lj_pkg::S2_QW-1:0]    w_d1_q;
    lj_pkg::t_item               w_d1_item, w_m1_in;

    logic                        w_m1_v, w_m2_v, w_m3_v, w_m4_v, w_m5_v;
    logic [0:0][PW-1:0]          w_m1_p, w_m2_p, w_m3_p, w_m4_p;
    logic [2:0][PW-1:0]          w_m5_p;
    lj_pkg::t_item               w_m1_item, w_m2_item, w_m3_item, w_m4_item, w_m5_item;
    logic [0:0][MW-1:0]          w_m1_a, w_m2_a, w_m2_b, w_m3_a, w_m3_b, w_m4_a, w_m4_b;
    logic [2:0][MW-1:0]          w_m5_a, w_m5_b;

    logic                        r_s4_v, r_s6_v, r_s7_v, r_s8_v, r_s9_v;
    lj_pkg::t_item               r_s4_item, r_s6_item, r_s7_item, r_s8_item, r_s9_item;
    lj_pkg::t_item               n_s4_item, n_s6_item, n_s7_item, n_s8_item, n_s9_item;

    logic                        w_d2_v, w_d2_sat;
    logic [lj_pkg::T_QW-1:0]     w_d2_q, w_t;
    lj_pkg::t_item               w_d2_item, w_m5_in;

    lj_pkg::t_out                w_res;
    logic                        r_out_v, r_skid_v;
    lj_pkg::t_out                r_out, r_skid;
    logic                        w_push, w_take;

    // config write port, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff_sq  <= lj_pkg::RST_CUTOFF_SQ;
            r_sigma_sq   <= lj_pkg::RST_SIGMA_SQ;
            r_well_depth <= lj_pkg::RST_WELL_DEPTH;
            r_box        <= {3{lj_pkg::RST_BOX_LEN}};
            r_species_a  <= lj_pkg::RST_SPECIES;
            r_species_b  <= lj_pkg::RST_SPECIES;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lj_pkg::CFG_CUTOFF_SQ:  r_cutoff_sq  <= i_cfg_data;
                lj_pkg::CFG_SIGMA_SQ:   r_sigma_sq   <= i_cfg_data;
                lj_pkg::CFG_WELL_DEPTH: r_well_depth <= i_cfg_data[31:0];
                lj_pkg::CFG_BOX_LEN_X:  r_box[0]     <= i_cfg_data[30:0];
                lj_pkg::CFG_BOX_LEN_Y:  r_box[1]     <= i_cfg_data[30:0];
                lj_pkg::CFG_BOX_LEN_Z:  r_box[2]     <= i_cfg_data[30:0];
                lj_pkg::CFG_SPECIES_A:  r_species_a  <= i_cfg_data[7:0];
                lj_pkg::CFG_SPECIES_B:  r_species_b  <= i_cfg_data[7:0];
                default:                r_species_b  <= r_species_b;
            endcase
        end
    end

    // 48 * epsilon, kept ready off the item path
    always_ff @(posedge i_clk) begin
        r_wd48 <= {r_well_depth, 5'd0} + {1'b0, r_well_depth, 4'd0} + 38'd0;
    end

    // whole pipeline moves unless the skid register is occupied
    assign w_en       = !r_skid_v;
    assign o_in_ready = w_en;

    // front end
    lj_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_in_valid),
        .i_in        (i_in),
        .i_box       (r_box),
        .i_species_a (r_species_a),
        .i_species_b (r_species_b),
        .i_cutoff_sq (r_cutoff_sq),
        .o_valid     (w_fe_v),
        .o_item      (w_fe_item)
    );

    // s2 = sigma_sq * 2^32 / r2
    lj_div #(.QW(lj_pkg::S2_QW), .SideW(IW)) u_div_s2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fe_v),
        .i_rem0  ({16'd0, r_sigma_sq[47:16]}),
        .i_low   ({r_sigma_sq[15:0], 32'd0}),
        .i_den   (w_fe_item.r2),
        .i_side  (w_fe_item),
        .o_valid (w_d1_v),
        .o_quo   (w_d1_q),
        .o_sat   (w_d1_sat),
        .o_side  (w_d1_item)
    );

    always_comb begin
        w_m1_in     = w_d1_item;
        w_m1_in.s2  = w_d1_sat ? lj_pkg::CAP48 : w_d1_q;
        w_m1_in.sat = w_d1_item.sat | w_d1_sat;
    end
    assign w_m1_a[0] = {16'd0, w_m1_in.s2};

    // s2 * s2
    lj_mul #(.Lanes(1), .SideW(IW)) u_mul_s4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d1_v),
        .i_a     (w_m1_a),
        .i_b     (w_m1_a),
        .i_side  (w_m1_in),
        .o_valid (w_m1_v),
        .o_prod  (w_m1_p),
        .o_side  (w_m1_item)
    );

    // pipeline valid bits of the clamp stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
            r_s8_v <= 1'b0;
            r_s9_v <= 1'b0;
        end else if (w_en) begin
            r_s4_v <= w_m1_v;
            r_s6_v <= w_m2_v;
            r_s7_v <= r_s6_v;
            r_s8_v <= w_m3_v;
            r_s9_v <= w_m4_v;
        end
    end

    // s4 clamp
    always_comb begin
        n_s4_item     = w_m1_item;
        n_s4_item.acc = {14'd0, (|w_m1_p[0][PW-1:80]) ? lj_pkg::CAP48 : w_m1_p[0][79:32]};
        n_s4_item.sat = w_m1_item.sat | (|w_m1_p[0][PW-1:80]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_item <= n_s4_item;
        end
    end

    assign w_m2_a[0] = {16'd0, r_s4_item.acc[47:0]};
    assign w_m2_b[0] = {16'd0, r_s4_item.s2};

    // s4 * s2
    lj_mul #(.Lanes(1), .SideW(IW)) u_mul_s6 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s4_v),
        .i_a     (w_m2_a),
        .i_b     (w_m2_b),
        .i_side  (r_s4_item),
        .o_valid (w_m2_v),
        .o_prod  (w_m2_p),
        .o_side  (w_m2_item)
    );

    // s6 clamp
    always_comb begin
        n_s6_item     = w_m2_item;
        n_s6_item.s6  = (|w_m2_p[0][PW-1:80]) ? lj_pkg::CAP48 : w_m2_p[0][79:32];
        n_s6_item.sat = w_m2_item.sat | (|w_m2_p[0][PW-1:80]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_item <= n_s6_item;
        end
    end

    // attraction or repulsion side and distance of s6 from one half
    always_comb begin
        n_s7_item      = r_s6_item;
        n_s7_item.gneg = (r_s6_item.s6 < lj_pkg::HALF);
        n_s7_item.acc  = {14'd0, (r_s6_item.s6 < lj_pkg::HALF)
                                 ? lj_pkg::HALF - r_s6_item.s6
                                 : r_s6_item.s6 - lj_pkg::HALF};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_item <= n_s7_item;
        end
    end

    assign w_m3_a[0] = {16'd0, r_s7_item.s6};
    assign w_m3_b[0] = {16'd0, r_s7_item.acc[47:0]};

    // s6 * |s6 - 0.5|
    lj_mul #(.Lanes(1), .SideW(IW)) u_mul_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s7_v),
        .i_a     (w_m3_a),
        .i_b     (w_m3_b),
        .i_side  (r_s7_item),
        .o_valid (w_m3_v),
        .o_prod  (w_m3_p),
        .o_side  (w_m3_item)
    );

    // g clamp
    always_comb begin
        n_s8_item     = w_m3_item;
        n_s8_item.acc = {14'd0, (|w_m3_p[0][PW-1:80]) ? lj_pkg::CAP48 : w_m3_p[0][79:32]};
        n_s8_item.sat = w_m3_item.sat | (|w_m3_p[0][PW-1:80]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s8_item <= n_s8_item;
        end
    end

    assign w_m4_a[0] = {26'd0, r_wd48};
    assign w_m4_b[0] = {16'd0, r_s8_item.acc[47:0]};

    // 48 * epsilon * g
    lj_mul #(.Lanes(1), .SideW(IW)) u_mul_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s8_v),
        .i_a     (w_m4_a),
        .i_b     (w_m4_b),
        .i_side  (r_s8_item),
        .o_valid (w_m4_v),
        .o_prod  (w_m4_p),
        .o_side  (w_m4_item)
    );

    // e clamp
    always_comb begin
        n_s9_item     = w_m4_item;
        n_s9_item.acc = (|w_m4_p[0][PW-1:78]) ? lj_pkg::CAP62 : w_m4_p[0][77:16];
        n_s9_item.sat = w_m4_item.sat | (|w_m4_p[0][PW-1:78]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s9_item <= n_s9_item;
        end
    end

    // t = e * 2^40 / r2
    lj_div #(.QW(lj_pkg::T_QW), .SideW(IW)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s9_v),
        .i_rem0  ({8'd0, r_s9_item.acc[61:22]}),
        .i_low   ({r_s9_item.acc[21:0], 40'd0}),
        .i_den   (r_s9_item.r2),
        .i_side  (r_s9_item),
        .o_valid (w_d2_v),
        .o_quo   (w_d2_q),
        .o_sat   (w_d2_sat),
        .o_side  (w_d2_item)
    );

    assign w_t = w_d2_sat ? lj_pkg::CAP62 : w_d2_q;

    always_comb begin
        w_m5_in     = w_d2_item;
        w_m5_in.sat = w_d2_item.sat | w_d2_sat;
        for (int k = 0; k < 3; k++) begin
            w_m5_a[k] = {2'd0, w_t};
            w_m5_b[k] = {40'd0, w_d2_item.mag[k]};
        end
    end

    // t * |d| per axis
    lj_mul #(.Lanes(3), .SideW(IW)) u_mul_f (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d2_v),
        .i_a     (w_m5_a),
        .i_b     (w_m5_b),
        .i_side  (w_m5_in),
        .o_valid (w_m5_v),
        .o_prod  (w_m5_p),
        .o_side  (w_m5_item)
    );

    // final clamp, sign and masking of pairs that do not interact
    always_comb begin
        logic [2:0][47:0] frc;
        logic             fneg, ovf, sat_f;
        logic [47:0]      fm;
        sat_f = 1'b0;
        for (int k = 0; k < 3; k++) begin
            fneg = w_m5_item.gneg ^ w_m5_item.neg[k];
            if (fneg) begin
                ovf = (|w_m5_p[k][PW-1:76]) || (w_m5_p[k][75] && (|w_m5_p[k][74:28]));
                fm  = ovf ? lj_pkg::FORCE_NEG : w_m5_p[k][75:28];
            end else begin
                ovf = |w_m5_p[k][PW-1:75];
                fm  = ovf ? lj_pkg::FORCE_POS : w_m5_p[k][75:28];
            end
            sat_f  = sat_f | ovf;
            frc[k] = w_m5_item.live ? (fneg ? 48'd0 - fm : fm) : 48'd0;
        end
        w_res.force_x   = frc[0];
        w_res.force_y   = frc[1];
        w_res.force_z   = frc[2];
        w_res.interacts = w_m5_item.inter;
        w_res.clipped   = w_m5_item.live & (w_m5_item.sat | sat_f);
    end

    // output register with skid stage
    assign w_push = w_en && w_m5_v;
    assign w_take = r_out_v && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_v || w_take) begin
                r_out   <= w_res;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= w_res;
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    // checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a beat while the output register is empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_out_ready) |=> (o_out_valid && !r_skid_v))
        else $error("skid beat not moved to the output after the output beat was taken");

    a_quiet_no_interact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.interacts) |->
            (o_out.force_x == '0 && o_out.force_y == '0 && o_out.force_z == '0
             && !o_out.clipped))
        else $error("non-interacting pair produced force or clip flag");

    a_clip_needs_interact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.clipped) |-> o_out.interacts)
        else $error("clip flag set on a pair outside the interaction");

endmodule
